// ----- hdl/half_sine_pwm_compare_generator_macros.svh -----
// Assertion macros shared by the half-sine PWM compare generator RTL.
`ifndef HALF_SINE_PWM_COMPARE_GENERATOR_MACROS_SVH
`define HALF_SINE_PWM_COMPARE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// check while out of reset
`define HSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check on every edge, reset included
`define HSP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HSP_ASSERT(label, prop, msg)
`define HSP_ASSERT_RST(label, prop, msg)
`endif

`endif

// ----- hdl/hsp_pkg.sv -----
// Types, constants and helper functions of the half-sine PWM compare generator.
package hsp_pkg;

  localparam int CARRIER_RATE = 10000;
  localparam int PEAK         = 4800;
  localparam int MAX_PULSES   = 2048;
  localparam int TABLE_DEPTH  = MAX_PULSES / 2;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

  localparam int FREQ_W = 13;
  localparam int CMP_W  = 13;
  localparam int IDX_W  = 12;
  localparam int HALF_W = IDX_W - 1;

  localparam int DIV_DW = 32;
  localparam int DIV_SW = 13;
  localparam int DIV_CW = $clog2(DIV_DW);

  localparam int HORNER_TERMS = 5;

  localparam logic [FREQ_W-1:0] FREQ_RESET   = 13'd10;
  localparam logic [IDX_W-1:0]  PULSES_RESET = 12'd1000;
  localparam logic [31:0]       PI_Q30       = 32'd3373259426;
  localparam logic [30:0]       ONE_Q30      = 31'h4000_0000;
  localparam logic [16:0]       S_ONE        = 17'h1_0000;
  localparam logic [16:0]       FOLD_HALF    = 17'h0_8000;

  typedef enum logic [3:0] {
    B_IDLE,
    B_START,
    B_PWAIT,
    B_KDIV,
    B_KWAIT,
    B_MT,
    B_MT2,
    B_MH,
    B_HDIV,
    B_MS,
    B_ME,
    B_WR
  } bld_state_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_ZERO,
    K_TABLE
  } cmp_kind_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                we;
    logic [TABLE_AW-1:0] addr;
    logic [CMP_W-1:0]    data;
  } tbl_wr_t;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] pulses;
  } bld_status_t;

  // Horner divisors of the sine series, x^11 term first: 110, 72, 42, 20, 6.
  // Shift out the power of two, then multiply by the rounded-up reciprocal of
  // the odd part and shift; exact for 32-bit dividends.
  function automatic logic [1:0] horner_pre(input logic [2:0] idx);
    logic [1:0] s;
    case (idx)
      3'd0:    s = 2'd1;
      3'd1:    s = 2'd3;
      3'd2:    s = 2'd1;
      3'd3:    s = 2'd2;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] horner_magic(input logic [2:0] idx);
    logic [31:0] m;
    case (idx)
      3'd0:    m = 32'd2498890064;
      3'd1:    m = 32'd3817748708;
      3'd2:    m = 32'd3272356036;
      3'd3:    m = 32'd3435973837;
      default: m = 32'd2863311531;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] horner_post(input logic [2:0] idx);
    logic [5:0] s;
    case (idx)
      3'd0:    s = 6'd37;
      3'd1:    s = 6'd35;
      3'd2:    s = 6'd36;
      3'd3:    s = 6'd34;
      default: s = 6'd33;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/half_sine_pwm_compare_generator.sv -----
// Top level: carrier-tick pipeline over the half-wave table, with builder and table RAM.
//
//  channel  direction  handshake               payload
//  cfg      in         cfg_valid / cfg_ready   cfg_sine_frequency[12:0]
//  in       in         in_valid / in_stall     in_tick
//  out      out        out_valid / out_stall   out_compare_value[12:0], out_phase_index[11:0],
//                                              out_period_restart
//
//  One transaction per cycle while in_stall is low; a result passes the table read stage and then
//  the output register. After reset and after each frequency write the builder fills the table,
//  each entry taking one division and two multiplies per series term; in_stall is high and
//  cfg_ready low meanwhile. An output stall holds one result in the output register and one in
//  the table stage.
`include "half_sine_pwm_compare_generator_macros.svh"

module half_sine_pwm_compare_generator import hsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FREQ_W-1:0] cfg_sine_frequency,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_tick,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CMP_W-1:0]  out_compare_value,
  output logic [IDX_W-1:0]  out_phase_index,
  output logic              out_period_restart
);

  bld_status_t         status;
  tbl_wr_t             tbl_wr;
  logic [TABLE_AW-1:0] ram_raddr;
  logic [CMP_W-1:0]    ram_rdata;
  logic [HALF_W-1:0]   half;

  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  cmp_kind_t           s0_kind;
  logic                s0_restart;
  logic                in_acc;

  logic                s1_valid_r;
  cmp_kind_t           s1_kind_r;
  logic [IDX_W-1:0]    s1_phase_r;
  logic                s1_restart_r;
  logic [TABLE_AW-1:0] s1_addr_r;
  logic                s1_adv;

  logic [CMP_W-1:0]    held_r, held_nxt;
  logic                out_valid_r;
  logic [CMP_W-1:0]    out_cmp_r;
  logic [IDX_W-1:0]    out_phase_r;
  logic                out_restart_r;

  hsp_build u_build (
    .clk (clk),
    .rst_n (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_sine_frequency (cfg_sine_frequency),
    .status (status),
    .tbl_wr (tbl_wr)
  );

  hsp_ram #(
    .WIDTH (CMP_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk (clk),
    .we (tbl_wr.we),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .re (!status.busy),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign half     = status.pulses[IDX_W-1:1];
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = status.busy || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // hold the read address while the table stage waits
  assign ram_raddr = (s1_valid_r && !s1_adv) ? s1_addr_r : cnt_r[TABLE_AW-1:0];

  always_comb begin
    s0_kind    = K_HOLD;
    s0_restart = 1'b0;
    cnt_nxt    = cnt_r;
    if (in_tick) begin
      if (cnt_r < IDX_W'(half)) begin
        s0_kind = K_TABLE;
        cnt_nxt = cnt_r + IDX_W'(1);
      end else if (cnt_r < status.pulses) begin
        s0_kind = K_ZERO;
        cnt_nxt = cnt_r + IDX_W'(1);
      end else begin
        s0_restart = 1'b1;
        cnt_nxt    = IDX_W'(1);
      end
    end
  end

  always_comb begin
    case (s1_kind_r)
      K_TABLE: held_nxt = ram_rdata;
      K_ZERO:  held_nxt = '0;
      default: held_nxt = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_r      <= cnt_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r    <= s0_kind;
      s1_phase_r   <= cnt_nxt;
      s1_restart_r <= s0_restart;
      s1_addr_r    <= cnt_r[TABLE_AW-1:0];
    end
    if (s1_adv) begin
      out_cmp_r     <= held_nxt;
      out_phase_r   <= s1_phase_r;
      out_restart_r <= s1_restart_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_compare_value  = out_cmp_r;
  assign out_phase_index    = out_phase_r;
  assign out_period_restart = out_restart_r;

  `HSP_ASSERT(a_acc_to_s1, in_acc |=> s1_valid_r, "accepted transaction missing from table stage")
  `HSP_ASSERT(a_held_stable, !s1_adv |=> $stable(held_r), "held compare changed without a result")
  `HSP_ASSERT(a_wrap_phase, (in_acc && s0_restart) |=> (cnt_r == IDX_W'(1)), "wrap did not restart phase")
  `HSP_ASSERT_RST(a_rst_clear, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipeline not cleared by reset")

endmodule

// ----- hdl/hsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/hsp_div.sv -----
// Restoring divider, one quotient bit per cycle.
module hsp_div import hsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] dvd_r;
  logic [DIV_SW-1:0] dvs_r;
  logic [DIV_SW-1:0] rem_r;
  logic [DIV_SW:0]   rem_sh;
  logic [DIV_SW:0]   rem_diff;
  logic              ge;

  assign rem_sh   = {rem_r, dvd_r[DIV_DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? rem_diff[DIV_SW-1:0] : rem_sh[DIV_SW-1:0];
        dvd_r <= {dvd_r[DIV_DW-2:0], ge};
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(DIV_DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;

endmodule

// ----- hdl/hsp_build.sv -----
// Frequency register and half-wave table builder: pulse count, phase, sine series.
`include "half_sine_pwm_compare_generator_macros.svh"

module hsp_build import hsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FREQ_W-1:0] cfg_sine_frequency,
  output bld_status_t       status,
  output tbl_wr_t           tbl_wr
);

  bld_state_t        state_r, state_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [IDX_W-1:0]  pulses_r, pulses_nxt;
  logic [HALF_W-1:0] k_r, k_nxt;
  logic [15:0]       x_r, x_nxt;
  logic [30:0]       t_r, t_nxt;
  logic [31:0]       t2_r, t2_nxt;
  logic [31:0]       h_r, h_nxt;
  logic [30:0]       r_r, r_nxt;
  logic [2:0]        i_r, i_nxt;
  logic [16:0]       s_r, s_nxt;
  logic [CMP_W-1:0]  entry_r, entry_nxt;

  logic [HALF_W-1:0] half;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  hsp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign half = pulses_r[IDX_W-1:1];
  assign prod = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_START;
      freq_r   <= FREQ_RESET;
      pulses_r <= PULSES_RESET;
      k_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      freq_r   <= freq_nxt;
      pulses_r <= pulses_nxt;
      k_r      <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    t_r     <= t_nxt;
    t2_r    <= t2_nxt;
    h_r     <= h_nxt;
    r_r     <= r_nxt;
    i_r     <= i_nxt;
    s_r     <= s_nxt;
    entry_r <= entry_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    freq_nxt    = freq_r;
    pulses_nxt  = pulses_r;
    k_nxt       = k_r;
    x_nxt       = x_r;
    t_nxt       = t_r;
    t2_nxt      = t2_r;
    h_nxt       = h_r;
    r_nxt       = r_r;
    i_nxt       = i_r;
    s_nxt       = s_r;
    entry_nxt   = entry_r;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    tbl_wr.we   = 1'b0;
    tbl_wr.addr = k_r[TABLE_AW-1:0];
    tbl_wr.data = entry_r;
    cfg_ready   = (state_r == B_IDLE);
    case (state_r)
      B_IDLE: begin
        if (cfg_valid) begin
          freq_nxt  = cfg_sine_frequency;
          state_nxt = B_START;
        end
      end
      B_START: begin
        if (freq_r == '0) begin
          pulses_nxt = IDX_W'(MAX_PULSES);
          k_nxt      = '0;
          state_nxt  = B_KDIV;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_DW'(CARRIER_RATE);
          div_req.divisor  = freq_r;
          state_nxt        = B_PWAIT;
        end
      end
      B_PWAIT: begin
        if (div_rsp.done) begin
          pulses_nxt = (div_rsp.quot > DIV_DW'(MAX_PULSES)) ? IDX_W'(MAX_PULSES)
                                                          : div_rsp.quot[IDX_W-1:0];
          k_nxt      = '0;
          state_nxt  = B_KDIV;
        end
      end
      B_KDIV: begin
        if (k_r >= half) begin
          state_nxt = B_IDLE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_DW'({k_r, 16'h0000});
          div_req.divisor  = DIV_SW'(half);
          state_nxt        = B_KWAIT;
        end
      end
      B_KWAIT: begin
        if (div_rsp.done) begin
          // fold phase about one half
          x_nxt     = (div_rsp.quot[16:0] > FOLD_HALF) ? 16'(S_ONE - div_rsp.quot[16:0])
                                                       : div_rsp.quot[15:0];
          state_nxt = B_MT;
        end
      end
      B_MT: begin
        mul_a     = 32'(x_r);
        mul_b     = PI_Q30;
        t_nxt     = prod[46:16];
        state_nxt = B_MT2;
      end
      B_MT2: begin
        mul_a     = {1'b0, t_r};
        mul_b     = {1'b0, t_r};
        t2_nxt    = prod[61:30];
        r_nxt     = ONE_Q30;
        i_nxt     = '0;
        state_nxt = B_MH;
      end
      B_MH: begin
        mul_a     = t2_r;
        mul_b     = {1'b0, r_r};
        h_nxt     = prod[61:30];
        state_nxt = B_HDIV;
      end
      B_HDIV: begin
        mul_a = h_r >> horner_pre(i_r);
        mul_b = horner_magic(i_r);
        r_nxt = ONE_Q30 - 31'(prod >> horner_post(i_r));
        if (i_r == 3'(HORNER_TERMS - 1)) begin
          state_nxt = B_MS;
        end else begin
          i_nxt     = i_r + 3'd1;
          state_nxt = B_MH;
        end
      end
      B_MS: begin
        mul_a     = {1'b0, t_r};
        mul_b     = {1'b0, r_r};
        s_nxt     = (prod[60:44] > S_ONE) ? S_ONE : prod[60:44];
        state_nxt = B_ME;
      end
      B_ME: begin
        mul_a     = 32'(PEAK);
        mul_b     = 32'(s_r);
        entry_nxt = prod[28:16];
        state_nxt = B_WR;
      end
      B_WR: begin
        tbl_wr.we = 1'b1;
        k_nxt     = k_r + HALF_W'(1);
        state_nxt = B_KDIV;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign status.busy   = (state_r != B_IDLE);
  assign status.pulses = pulses_r;

  `HSP_ASSERT(a_wr_in_half, tbl_wr.we |-> (k_r < half), "table write beyond half wave")
  `HSP_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `HSP_ASSERT(a_pulses_max, pulses_r <= IDX_W'(MAX_PULSES), "pulse count above maximum")

endmodule
